// ----- rtl/bfpr_pkg.sv -----
// Shared types and codes for the boundary-first point renumbering block.
// No dependencies; imported by every other file of the block.
`default_nettype none

package bfpr_pkg;

   localparam int IDX_WIDTH  = 12;
   localparam int CNT_WIDTH  = 13;
   localparam int TAG_WIDTH  = 2;
   localparam int MAP_WIDTH  = TAG_WIDTH + IDX_WIDTH;

   // request codes
   localparam logic [1:0] REQ_START    = 2'd0;
   localparam logic [1:0] REQ_BOUNDARY = 2'd1;
   localparam logic [1:0] REQ_INTERNAL = 2'd2;
   localparam logic [1:0] REQ_READ     = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_ORDER = 2'd2;

   // map entry tags
   localparam logic [TAG_WIDTH-1:0] TAG_NONE     = 2'd0;
   localparam logic [TAG_WIDTH-1:0] TAG_BOUNDARY = 2'd1;
   localparam logic [TAG_WIDTH-1:0] TAG_INTERNAL = 2'd2;

   localparam logic signed [CNT_WIDTH-1:0] NEW_INDEX_NONE = -13'sd1;
   localparam logic [IDX_WIDTH-1:0]        RANK_MAX       = '1;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [IDX_WIDTH-1:0] point_index;
   } req_word_type;

   typedef struct packed {
      logic signed [CNT_WIDTH-1:0] new_index;
      logic [1:0]                  status;
      logic [CNT_WIDTH-1:0]        internal_count;
      logic                        ordered;
   } rsp_word_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0] tag;
      logic [IDX_WIDTH-1:0] rank;
   } map_entry_type;

endpackage

`default_nettype wire

// ----- rtl/bfpr_map_mem.sv -----
// Point map storage: one write port, one read port, registered read data.
// Depends on bfpr_pkg for the entry width.
`default_nettype none

module bfpr_map_mem #(
   parameter int DEPTH = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire logic [bfpr_pkg::MAP_WIDTH-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic      [bfpr_pkg::MAP_WIDTH-1:0] rd_data
);
   import bfpr_pkg::*;

   logic [MAP_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/boundary_first_point_renumber.sv -----
// Top level of the boundary-first point renumbering block.
// Depends on bfpr_pkg and bfpr_map_mem.
//
//   channel   ports                          handshake
//   request   start, busy, req_word          taken when start && !busy
//   response  rsp_valid, rsp_word            one-cycle strobe, no back-pressure
//   csr       csr_wr_en, csr_wr_data         written when csr_wr_en
//
// A reference or read issues the map read when taken; the registered read data
// feeds the tag/rank update, write-back and registered response in ST_READ.
// A start answers in the next cycle, then walks the map clearing one entry per
// cycle from entry 0 to MAX_POINTS-1, with busy high. Reset starts the same walk.
// busy covers the read-modify-write, so map accesses never overlap.
`default_nettype none

module boundary_first_point_renumber #(
   parameter int MAX_POINTS = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire bfpr_pkg::req_word_type       req_word,
   output logic                              rsp_valid,
   output bfpr_pkg::rsp_word_type            rsp_word,
   input  wire logic                         csr_wr_en,
   input  wire logic [bfpr_pkg::CNT_WIDTH-1:0] csr_wr_data
);
   import bfpr_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POINTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic [CNT_WIDTH-1:0] num_points_ff;
   logic [CNT_WIDTH-1:0] bcount_ff, bcount_in;
   logic [CNT_WIDTH-1:0] inext_ff, inext_in;
   logic                 ordered_ff, ordered_in;
   logic                 phase_ff, phase_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [1:0]           op_ff;
   logic [IDX_WIDTH-1:0] idx_ff;
   logic [AW-1:0]        addr_ff;
   logic                 in_range_ff;

   logic                 accept;
   logic                 in_range_now;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   map_entry_type        mem_wr_data;
   logic [MAP_WIDTH-1:0] mem_rd_raw;
   map_entry_type        cur;
   logic [CNT_WIDTH-1:0] icount_before, icount_after;
   logic [CNT_WIDTH:0]   shifted;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign in_range_now = ({1'b0, req_word.point_index} < num_points_ff)
                      && (32'(req_word.point_index) < MAX_POINTS);

   bfpr_map_mem #(
      .DEPTH (MAX_POINTS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (AW'(req_word.point_index)),
      .rd_data (mem_rd_raw)
   );

   assign cur = mem_rd_raw;

   always_comb begin
      icount_before = (num_points_ff > bcount_ff) ? (num_points_ff - bcount_ff) : '0;
      icount_after  = (num_points_ff > bcount_in) ? (num_points_ff - bcount_in) : '0;
   end

   // boundary rank shifted past the internal block, computed after the step
   assign shifted = {2'b00, cur.rank} + {1'b0, icount_after};

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      bcount_in    = bcount_ff;
      inext_in     = inext_ff;
      ordered_in   = ordered_ff;
      phase_in     = phase_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = '{tag: TAG_NONE, rank: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.req_type == REQ_START)) begin
               bcount_in    = '0;
               inext_in     = '0;
               ordered_in   = 1'b1;
               phase_in     = 1'b0;
               sweep_in     = '0;
               state_in     = ST_CLEAR;
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{new_index: NEW_INDEX_NONE, status: STATUS_OK,
                                internal_count: num_points_ff, ordered: 1'b1};
            end else if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rsp_word_in.new_index = NEW_INDEX_NONE;
            rsp_word_in.status    = STATUS_OK;
            if (!in_range_ff) begin
               rsp_word_in.status = STATUS_RANGE;
            end else begin
               case (op_ff)
                  REQ_BOUNDARY: begin
                     if (phase_ff) begin
                        rsp_word_in.status = STATUS_ORDER;
                     end else if (cur.tag == TAG_NONE) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '{tag: TAG_BOUNDARY, rank: bcount_ff[IDX_WIDTH-1:0]};
                        bcount_in   = bcount_ff + 1'b1;
                     end
                  end
                  REQ_INTERNAL: begin
                     phase_in = 1'b1;
                     if (cur.tag == TAG_NONE) begin
                        if ({1'b0, idx_ff} >= icount_before) begin
                           ordered_in = 1'b0;
                        end
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '{tag: TAG_INTERNAL, rank: inext_ff[IDX_WIDTH-1:0]};
                        inext_in    = inext_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (cur.tag == TAG_BOUNDARY) begin
                        rsp_word_in.new_index = (shifted > {2'b00, RANK_MAX})
                           ? $signed({1'b0, RANK_MAX})
                           : $signed(shifted[CNT_WIDTH-1:0]);
                     end else if (cur.tag == TAG_INTERNAL) begin
                        rsp_word_in.new_index = $signed({1'b0, cur.rank});
                     end
                  end
               endcase
            end
            rsp_word_in.internal_count = icount_after;
            rsp_word_in.ordered        = ordered_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         num_points_ff <= '0;
         bcount_ff     <= '0;
         inext_ff      <= '0;
         ordered_ff    <= 1'b1;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         bcount_ff     <= bcount_in;
         inext_ff      <= inext_in;
         ordered_ff    <= ordered_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            num_points_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (accept) begin
         op_ff       <= req_word.req_type;
         idx_ff      <= req_word.point_index;
         addr_ff     <= AW'(req_word.point_index);
         in_range_ff <= in_range_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- rtl/bfpr_checker.sv -----
// Port-level checks for boundary_first_point_renumber, with the bind that
// attaches them. Depends on bfpr_pkg.
`default_nettype none

module bfpr_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire bfpr_pkg::req_word_type req_word,
   input wire logic                   rsp_valid,
   input wire bfpr_pkg::rsp_word_type rsp_word
);
   import bfpr_pkg::*;

   // a start answers next cycle with a cleared map and then walks
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.req_type == REQ_START |=>
         rsp_valid && busy && rsp_word.ordered && rsp_word.status == STATUS_OK
         && rsp_word.new_index == NEW_INDEX_NONE)
      else $error("start word not answered as a cleared map");

   // any other word shows busy without a reply in ST_READ, then answers with busy low
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.req_type != REQ_START |=>
         busy && !rsp_valid ##1 rsp_valid && !busy)
      else $error("reference word not answered on time");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STATUS_OK |-> rsp_word.new_index == NEW_INDEX_NONE)
      else $error("rejected word carries a mapping");

   // only a start taken while a reply strobes can strobe in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid
         || $past(start && !busy && req_word.req_type == REQ_START))
      else $error("responses back to back");

endmodule

bind boundary_first_point_renumber bfpr_checker u_bfpr_checker (.*);

`default_nettype wire

// ----- bench/bfpr_tb_pkg.sv -----
// Scoreboard for the boundary-first point renumbering bench: predicts reply words.
// Depends on bfpr_pkg for the word types, request, status and tag codes.
`timescale 1ns / 1ps

package bfpr_tb_pkg;
   import bfpr_pkg::*;

   localparam int MAP_DEPTH = 4096;

   class renumber_scoreboard;
      logic [TAG_WIDTH-1:0] tag_of [MAP_DEPTH];
      logic [IDX_WIDTH-1:0] rank_of [MAP_DEPTH];
      logic [CNT_WIDTH-1:0] num_points;
      logic [CNT_WIDTH-1:0] boundary_seen;
      logic [CNT_WIDTH-1:0] internal_seen;
      logic                 ordered;
      logic                 internal_started;
      rsp_word_type         replies_due [$];
      int                   mismatch_count;
      int                   replies_checked;

      function new();
         num_points      = '0;
         mismatch_count  = 0;
         replies_checked = 0;
         clear_map();
      endfunction

      function void clear_map();
         foreach (tag_of[i]) begin
            tag_of[i]  = TAG_NONE;
            rank_of[i] = '0;
         end
         boundary_seen    = '0;
         internal_seen    = '0;
         ordered          = 1'b1;
         internal_started = 1'b0;
      endfunction

      // floors at zero when num_points is lowered mid-stream
      function logic [CNT_WIDTH-1:0] internal_count();
         return (num_points > boundary_seen) ? num_points - boundary_seen : '0;
      endfunction

      function void set_num_points(logic [CNT_WIDTH-1:0] value);
         num_points = value;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void note_request(req_word_type word);
         rsp_word_type         reply;
         logic [IDX_WIDTH-1:0] idx;
         int                   shifted;
         idx             = word.point_index;
         reply.new_index = NEW_INDEX_NONE;
         reply.status    = STATUS_OK;
         if (word.req_type == REQ_START) begin
            clear_map();
         end else if ({1'b0, idx} >= num_points) begin
            reply.status = STATUS_RANGE;
         end else if (word.req_type == REQ_BOUNDARY) begin
            if (internal_started) begin
               reply.status = STATUS_ORDER;
            end else if (tag_of[idx] == TAG_NONE) begin
               tag_of[idx]   = TAG_BOUNDARY;
               rank_of[idx]  = boundary_seen[IDX_WIDTH-1:0];
               boundary_seen = boundary_seen + 1'b1;
            end
         end else if (word.req_type == REQ_INTERNAL) begin
            internal_started = 1'b1;
            if (tag_of[idx] == TAG_NONE) begin
               if ({1'b0, idx} >= internal_count())
                  ordered = 1'b0;
               tag_of[idx]   = TAG_INTERNAL;
               rank_of[idx]  = internal_seen[IDX_WIDTH-1:0];
               internal_seen = internal_seen + 1'b1;
            end
         end else begin
            if (tag_of[idx] == TAG_BOUNDARY) begin
               // boundary ranks sit above the internal block, shifted on read
               shifted = int'(rank_of[idx]) + int'(internal_count());
               if (shifted > int'(RANK_MAX))
                  reply.new_index = {1'b0, RANK_MAX};
               else
                  reply.new_index = shifted[CNT_WIDTH-1:0];
            end else if (tag_of[idx] == TAG_INTERNAL) begin
               reply.new_index = {1'b0, rank_of[idx]};
            end
         end
         reply.internal_count = internal_count();
         reply.ordered        = ordered;
         replies_due.push_back(reply);
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= 100)
            $display("mismatch at reply %0d: %s", replies_checked, what);
      endtask

      task check_response(rsp_word_type got);
         rsp_word_type want;
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("reply word %h with nothing outstanding", got));
            return;
         end
         want = replies_due.pop_front();
         replies_checked++;
         if (got.new_index !== want.new_index)
            report_mismatch($sformatf("new_index %0d, want %0d",
                                      got.new_index, want.new_index));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.internal_count !== want.internal_count)
            report_mismatch($sformatf("internal_count %0d, want %0d",
                                      got.internal_count, want.internal_count));
         if (got.ordered !== want.ordered)
            report_mismatch($sformatf("ordered %0b, want %0b", got.ordered, want.ordered));
      endtask
   endclass

endpackage

// ----- bench/tb_boundary_first_point_renumber.sv -----
// Top of the bench for boundary_first_point_renumber: directed words, then random
// face-list phases and noise, checked against renumber_scoreboard from bfpr_tb_pkg.
`timescale 1ns / 1ps

module tb_boundary_first_point_renumber;
   import bfpr_pkg::*;
   import bfpr_tb_pkg::*;

   localparam int WORD_TARGET  = 1500;
   localparam int START_BUDGET = 60;
   localparam int CYCLE_LIMIT  = 1200000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_word_type         req_word;
   logic                 rsp_valid;
   rsp_word_type         rsp_word;
   logic                 csr_wr_en;
   logic [CNT_WIDTH-1:0] csr_wr_data;

   renumber_scoreboard   sb;
   int                   words_sent;
   int                   starts_sent;
   int                   csr_writes;
   int                   cycle_count;

   boundary_first_point_renumber i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // results cannot be held off: check every strobe as it goes by
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_response(rsp_word);
   end

   // returns at the edge that takes the word; start stays high unless a gap follows
   task automatic send_word(input logic [1:0] kind, input logic [IDX_WIDTH-1:0] idx);
      req_word_type word;
      word.req_type    = kind;
      word.point_index = idx;
      req_word <= word;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sb.note_request(word);
      words_sent++;
      if (kind == REQ_START)
         starts_sent++;
      if ((words_sent < 700 || words_sent >= 1000) && $urandom_range(0, 99) < 23) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_num_points(input logic [CNT_WIDTH-1:0] value);
      start <= 1'b0;
      while (sb.pending() != 0 || busy)
         @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      sb.set_num_points(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   // mostly in range, sometimes right at the limit or anywhere in the 12-bit space
   function automatic logic [IDX_WIDTH-1:0] pick_index(input int span);
      int roll;
      roll = $urandom_range(0, 19);
      if (span == 0 || roll < 2)
         return IDX_WIDTH'($urandom_range(0, 4095));
      if (roll == 2)
         return IDX_WIDTH'(span - 1);
      if (roll == 3 && span < 4096)
         return IDX_WIDTH'(span);
      return IDX_WIDTH'($urandom_range(0, span - 1));
   endfunction

   task automatic run_phase();
      int         span;
      int         nb;
      int         ni;
      int         nr;
      int         roll;
      logic [1:0] kind;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         span = 0;
      else if (roll < 8)
         span = 4096;
      else if (roll < 11)
         span = 4095;
      else if (roll < 15)
         span = 1;
      else if (roll < 22)
         span = $urandom_range(0, 4096);
      else
         span = $urandom_range(2, 48);
      write_num_points(span[CNT_WIDTH-1:0]);
      if ($urandom_range(0, 99) < 80) begin
         // face list: boundary refs, then mostly internal refs with stray boundary refs, reads sprinkled in;
         // skipping the start keeps the old map under the new point count
         if (starts_sent < START_BUDGET && $urandom_range(0, 9) != 0)
            send_word(REQ_START, pick_index(span));
         nb = $urandom_range(0, (span < 24 ? span : 24) + 2);
         ni = $urandom_range(0, (span < 24 ? span : 24) + 2);
         nr = $urandom_range(1, 8);
         repeat (nb) begin
            if ($urandom_range(0, 4) == 0)
               send_word(REQ_READ, pick_index(span));
            else
               send_word(REQ_BOUNDARY, pick_index(span));
         end
         repeat (ni) begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
               send_word(REQ_READ, pick_index(span));
            else if (roll < 22)
               send_word(REQ_BOUNDARY, pick_index(span));
            else
               send_word(REQ_INTERNAL, pick_index(span));
         end
         repeat (nr)
            send_word(REQ_READ, pick_index(span));
      end else begin
         repeat ($urandom_range(5, 30)) begin
            kind = 2'($urandom_range(0, 3));
            if (kind == REQ_START && (starts_sent >= START_BUDGET || $urandom_range(0, 3) != 0))
               kind = REQ_READ;
            send_word(kind, pick_index(span));
         end
      end
   endtask

   initial begin
      sb          = new();
      words_sent  = 0;
      starts_sent = 0;
      csr_writes  = 0;
      cycle_count = 0;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_word    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset clears the map with a full walk
      while (busy)
         @(posedge clock);

      // empty map: every reference is out of range
      write_num_points(13'd0);
      send_word(REQ_READ, 12'd0);
      send_word(REQ_BOUNDARY, 12'hFFF);
      send_word(REQ_START, 12'd0);

      write_num_points(13'd4096);
      send_word(REQ_START, 12'hABC);
      send_word(REQ_BOUNDARY, 12'hFFF);
      send_word(REQ_BOUNDARY, 12'd0);
      send_word(REQ_BOUNDARY, 12'd0);
      send_word(REQ_INTERNAL, 12'd5);
      send_word(REQ_INTERNAL, 12'd0);
      send_word(REQ_INTERNAL, 12'd100);
      send_word(REQ_INTERNAL, 12'd4094);
      send_word(REQ_BOUNDARY, 12'd7);
      send_word(REQ_INTERNAL, 12'd5);
      send_word(REQ_READ, 12'hFFF);
      send_word(REQ_READ, 12'd0);
      send_word(REQ_READ, 12'd5);
      send_word(REQ_READ, 12'd100);
      send_word(REQ_READ, 12'd4094);
      send_word(REQ_READ, 12'd3000);
      send_word(REQ_READ, 12'd7);

      // shrink below the boundary count: internal count floors at zero
      write_num_points(13'd1);
      send_word(REQ_READ, 12'd0);
      send_word(REQ_READ, 12'd5);
      send_word(REQ_INTERNAL, 12'd0);

      while (words_sent < WORD_TARGET)
         run_phase();

      start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("sent %0d request words (%0d starts) over %0d csr writes",
               words_sent, starts_sent, csr_writes);
      $display("checked %0d replies, %0d mismatches", sb.replies_checked, sb.mismatch_count);
      if (sb.mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- boundary_first_point_renumber.f -----
rtl/bfpr_pkg.sv
rtl/bfpr_map_mem.sv
rtl/boundary_first_point_renumber.sv
rtl/bfpr_checker.sv
bench/bfpr_tb_pkg.sv
bench/tb_boundary_first_point_renumber.sv
